FILE: hdl/randomized_prim_maze_carver_macros.svh
// Assertion macros for the maze carver RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef RANDOMIZED_PRIM_MAZE_CARVER_MACROS_SVH
`define RANDOMIZED_PRIM_MAZE_CARVER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RPM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RPM_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPM_ASSERT(label, clk, rst_n, prop, msg)
`define RPM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: hdl/rpm_pkg.sv
// Package for the maze carver: constants, codes, word types, states and the xorshift step.
// No dependencies.
package rpm_pkg;
	localparam int GridSizeDef = 21;
	localparam int ListDepthDef = 2048;
	localparam int CoordW = 6;
	localparam int CellAddrW = 12;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0, OP_START = 2'd1, OP_STEP = 2'd2, OP_NONE = 2'd3
	} op_t;
	localparam logic [1:0] KIND_WALL = 2'd0;
	localparam logic [1:0] KIND_OPEN = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;
	localparam logic [1:0] KIND_BAD = 2'd3;
	localparam logic [1:0] REG_SEED = 2'd0;
	localparam logic [1:0] REG_ROW = 2'd1;
	localparam logic [1:0] REG_COL = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [5:0] cell_row;
		logic [5:0] cell_col;
		logic [1:0] cell_kind;
	} in_word_t;

	typedef struct packed {
		logic       carved;
		logic [5:0] carved_row;
		logic [5:0] carved_col;
		logic       done_res;
		logic       list_overflow;
	} out_word_t;

	typedef enum logic [4:0] {
		S_IDLE, S_RNG, S_DIV, S_RDW, S_RDW2, S_NB_RD, S_NB_WT, S_NB_CHK,
		S_OPEN, S_PU_RD, S_PU_WT, S_PU_CHK, S_CMP_RD, S_CMP_WT, S_CMP_CHK, S_DONE
	} state_t;

	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction
endpackage

FILE: hdl/rpm_ram.sv
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
module rpm_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/rpm_divider.sv
// Restoring divider: 32-bit dividend mod a narrow divisor, one bit a cycle.
// Depends on rpm_pkg.
module rpm_divider #(
	parameter int DivW = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [31:0]     dividend,
	input  logic [DivW-1:0] divisor,
	output logic            ready,
	output logic [DivW-1:0] remainder
);
	import rpm_pkg::*;
	logic [31:0]   quo_q;
	logic [DivW:0] rem_q;
	logic [DivW-1:0] div_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic [DivW+1:0] trial;

	assign trial = {rem_q, quo_q[31]} - {2'b00, div_q};

	// shift one dividend bit into the partial remainder per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], 1'b0};
			if (!trial[DivW+1]) rem_q <= trial[DivW:0];
			else rem_q <= {rem_q[DivW-1:0], quo_q[31]};
		end
	end

	assign ready = !busy_q && !go;
	assign remainder = rem_q[DivW-1:0];
endmodule

FILE: hdl/randomized_prim_maze_carver.sv
// Randomized Prim maze carver, one word at a time; busy stays high until the word ends.
// Load, off-grid start and idle words go straight to the strobe; a start opens the start
// cell and pushes its walls; a step takes a random value modulo the list count, reads that
// wall and neighbours, carves and pushes if exactly one is open, then compacts the list.
// A new word is taken in the strobe cycle; the strobe lasts one cycle, cannot be stalled.
// Reset clears list count, generator and config; grid and list memories are undefined.
module randomized_prim_maze_carver #(
	parameter int GRID_SIZE = rpm_pkg::GridSizeDef,
	parameter int LIST_DEPTH = rpm_pkg::ListDepthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rpm_pkg::in_word_t   in_word,
	output logic                res_valid,
	output rpm_pkg::out_word_t  res_word,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import rpm_pkg::*;
	`include "randomized_prim_maze_carver_macros.svh"

	localparam int LA = $clog2(LIST_DEPTH);
	localparam int CW = LA + 1;
	localparam logic [CoordW:0] GS = (CoordW+1)'(GRID_SIZE);
	localparam logic [CW-1:0] LD = CW'(LIST_DEPTH);

	state_t state_q, state_d;
	logic [31:0] seed_q, rng_q;
	logic [31:0] rng_nx;
	logic [5:0]  srow_q, scol_q;
	logic [CW-1:0] count_q, rd_q, wr_q;
	logic [5:0]  wr_row_q, wr_col_q;   // wall / cell being processed
	logic [2:0]  nb_q;                  // neighbour index 0..3
	logic [2:0]  open_cnt_q;
	logic        carved_q, ovf_q, from_start_q;
	logic [11:0] wall_q;

	// grid memory port
	logic        g_we;
	logic [11:0] g_waddr, g_raddr;
	logic [1:0]  g_wdata, g_rdata;
	// list memory port
	logic          l_we;
	logic [LA-1:0] l_waddr, l_raddr;
	logic [11:0]   l_wdata, l_rdata;

	rpm_ram #(.Width(2), .Depth(4096)) u_grid (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata));
	rpm_ram #(.Width(12), .Depth(1 << LA)) u_list (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata));

	// advance the generator before the index is taken
	assign rng_nx = xorshift(rng_q);

	logic div_go, div_ready;
	logic [CW-1:0] div_rem;
	rpm_divider #(.DivW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(rng_nx),
		.divisor(count_q), .ready(div_ready), .remainder(div_rem));

	// neighbour coordinate of current cell (up, right, down, left)
	logic       nb_ok;
	logic [5:0] nb_r, nb_c;
	always_comb begin
		nb_ok = 1'b0;
		nb_r = wr_row_q;
		nb_c = wr_col_q;
		case (nb_q[1:0])
			2'd0: begin
				nb_ok = wr_row_q != 6'd0;
				nb_r = wr_row_q - 6'd1;
			end
			2'd1: begin
				nb_ok = ({1'b0, wr_col_q} + 7'd1) < GS;
				nb_c = wr_col_q + 6'd1;
			end
			2'd2: begin
				nb_ok = ({1'b0, wr_row_q} + 7'd1) < GS;
				nb_r = wr_row_q + 6'd1;
			end
			default: begin
				nb_ok = wr_col_q != 6'd0;
				nb_c = wr_col_q - 6'd1;
			end
		endcase
	end

	logic in_grid_ld, in_grid_st;
	assign in_grid_ld = {1'b0, in_word.cell_row} < GS && {1'b0, in_word.cell_col} < GS;
	assign in_grid_st = {1'b0, srow_q} < GS && {1'b0, scol_q} < GS;

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		g_we = 1'b0;
		g_waddr = {nb_r, nb_c};
		g_wdata = KIND_OPEN;
		g_raddr = {nb_r, nb_c};
		l_we = 1'b0;
		l_waddr = wr_q[LA-1:0];
		l_wdata = {nb_r, nb_c};
		l_raddr = rd_q[LA-1:0];
		div_go = 1'b0;
		case (state_q)
			S_IDLE: if (start) begin
				case (in_word.operation)
					OP_LOAD: begin
						g_we = in_grid_ld;
						g_waddr = {in_word.cell_row, in_word.cell_col};
						g_wdata = (in_word.cell_kind == KIND_BAD) ? KIND_OTHER
							: in_word.cell_kind;
						state_d = S_DONE;
					end
					OP_START: state_d = in_grid_st ? S_OPEN : S_DONE;
					OP_STEP: state_d = (count_q != '0) ? S_RNG : S_DONE;
					default: state_d = S_DONE;
				endcase
			end
			S_RNG: begin
				div_go = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: if (div_ready) state_d = S_RDW;
			S_RDW: begin
				l_raddr = div_rem[LA-1:0];
				state_d = S_RDW2;
			end
			S_RDW2: state_d = S_NB_RD;
			S_NB_RD: state_d = S_NB_WT;
			S_NB_WT: state_d = S_NB_CHK;
			S_NB_CHK: begin
				if (nb_q == 3'd3)
					state_d = S_OPEN;
				else
					state_d = S_NB_RD;
			end
			S_OPEN: begin
				g_we = from_start_q || open_cnt_q == 3'd1;
				g_waddr = {wr_row_q, wr_col_q};
				state_d = g_we ? S_PU_RD : (from_start_q ? S_DONE : S_CMP_RD);
			end
			S_PU_RD: state_d = S_PU_WT;
			S_PU_WT: state_d = S_PU_CHK;
			S_PU_CHK: begin
				l_we = nb_ok && g_rdata == KIND_WALL && count_q < LD;
				l_waddr = count_q[LA-1:0];
				if (nb_q == 3'd3)
					state_d = from_start_q ? S_DONE : S_CMP_RD;
				else
					state_d = S_PU_RD;
			end
			S_CMP_RD: state_d = (rd_q < count_q) ? S_CMP_WT : S_DONE;
			S_CMP_WT: state_d = S_CMP_CHK;
			S_CMP_CHK: begin
				l_we = l_rdata != wall_q;
				l_wdata = l_rdata;
				state_d = S_CMP_RD;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd1;
			srow_q <= 6'd1;
			scol_q <= 6'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEED: seed_q <= cfg_data;
				REG_ROW: srow_q <= cfg_data[5:0];
				REG_COL: scol_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// datapath control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q <= 32'd1;
			count_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			nb_q <= '0;
			open_cnt_q <= '0;
			carved_q <= 1'b0;
			ovf_q <= 1'b0;
			from_start_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					carved_q <= 1'b0;
					ovf_q <= 1'b0;
					nb_q <= '0;
					open_cnt_q <= '0;
					from_start_q <= in_word.operation == OP_START;
					if (in_word.operation == OP_START) begin
						rng_q <= (seed_q != 32'd0) ? seed_q : 32'd1;
						count_q <= '0;
					end
				end
				S_RNG: rng_q <= rng_nx;
				S_NB_CHK: begin
					if (nb_ok && g_rdata == KIND_OPEN) open_cnt_q <= open_cnt_q + 3'd1;
					nb_q <= (nb_q == 3'd3) ? 3'd0 : nb_q + 3'd1;
				end
				S_OPEN: begin
					carved_q <= g_we;
					rd_q <= '0;
					wr_q <= '0;
				end
				S_PU_CHK: begin
					if (nb_ok && g_rdata == KIND_WALL) begin
						if (count_q < LD) count_q <= count_q + CW'(1);
						else ovf_q <= 1'b1;
					end
					nb_q <= (nb_q == 3'd3) ? 3'd0 : nb_q + 3'd1;
				end
				S_CMP_CHK: begin
					rd_q <= rd_q + CW'(1);
					if (l_we) wr_q <= wr_q + CW'(1);
				end
				S_CMP_RD: if (rd_q >= count_q) count_q <= wr_q;
				default: ;
			endcase
		end
	end

	// hold the cell under work: start cell, then the picked wall
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			wr_row_q <= srow_q;
			wr_col_q <= scol_q;
		end else if (state_q == S_RDW2) begin
			wr_row_q <= l_rdata[11:6];
			wr_col_q <= l_rdata[5:0];
			wall_q <= l_rdata;
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else res_valid <= state_q == S_DONE;
	end
	always_ff @(posedge clk) begin
		res_word.carved <= carved_q;
		res_word.carved_row <= carved_q ? wr_row_q : 6'd0;
		res_word.carved_col <= carved_q ? wr_col_q : 6'd0;
		res_word.done_res <= count_q == '0;
		res_word.list_overflow <= ovf_q;
	end

	assign busy = state_q != S_IDLE;

	`RPM_ASSERT(a_count_bound, clk, arst_n, count_q <= LD, "wall count beyond list depth")
	`RPM_ASSERT(a_res_idle, clk, arst_n, res_valid |-> !busy, "result while busy")
	`RPM_ASSERT(a_res_after_done, clk, arst_n, res_valid |-> $past(state_q) == S_DONE, "result without finish")
	`RPM_ASSERT(a_cmp_order, clk, arst_n, state_q == S_CMP_CHK |-> wr_q <= rd_q, "compaction overtook read")
endmodule
